/* sv/rsd_pkg.sv */
// Shared types and constants for the radix-64 stream decoder.
`default_nettype none
package rsd_pkg;

	typedef enum logic [2:0] {
		SYM_DATA,
		SYM_PAD,
		SYM_LF,
		SYM_CR,
		SYM_ILLEGAL
	} sym_kind_t;

	typedef struct packed {
		sym_kind_t  kind;
		logic [5:0] sextet;
	} sym_t;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_ILLEGAL    = 2'd1,
		STATUS_BAD_LENGTH = 2'd2
	} status_t;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_EQUAL = 8'h3D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;

	localparam logic [5:0] MASK_HI2 = 6'h30;
	localparam logic [5:0] MASK_LO4 = 6'h0F;
	localparam logic [5:0] MASK_MID = 6'h3C;
	localparam logic [5:0] MASK_LO2 = 6'h03;

endpackage
`default_nettype wire

/* sv/radix64_stream_decoder.sv */
// Top level of the radix-64 stream decoder.
// Input channel (in_valid/in_ready) carries one armored body character per
// item in char_byte, or source_empty to mark the end of the source.
// Output channel (out_valid/out_ready) carries at most one result per input
// item: a decoded byte (byte_valid) or the terminating result (last, status).
// The first character of each group of four gives no result; the second,
// third and fourth each give one byte. Single LF or CR characters give none.
// The stream ends on '=', a second LF or CR with no data between, an illegal
// character, or source_empty; one result with last set carries the status.
// Every item after that is accepted and dropped until reset.
// An item is registered in the input register on acceptance; its result is
// registered in the result register when the item is taken from there.
// Throughput: one item per cycle unless the receiver stalls, set by the
// single classify-and-shift step between the input and result registers.
// When the receiver stalls, the held result stays put, the input register
// keeps its item, and in_ready drops once the input register is full.
// Reset clears the group position, line break counts and the end flag, and
// empties both registers.
`default_nettype none
module radix64_stream_decoder
	import rsd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] char_byte,
	input  wire logic       source_empty,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic            last,
	output logic [1:0]      status
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       empty_s1;

	logic [1:0] group_pos_q;
	logic [5:0] held_q;
	logic [1:0] lf_count_q;
	logic [1:0] cr_count_q;
	logic       finished_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       byte_valid_q;
	logic       last_q;
	status_t    status_q;

	sym_t       sym;
	logic       take;
	logic       emit;
	logic       stop;
	status_t    stop_status;
	logic [7:0] data_byte;
	logic [1:0] lf_next;
	logic [1:0] cr_next;

	rsd_classify u_classify (
		.char_byte(char_s1),
		.sym      (sym)
	);

	assign take     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || take;
	assign lf_next  = lf_count_q + 2'd1;
	assign cr_next  = cr_count_q + 2'd1;

	always_comb begin
		stop        = 1'b0;
		emit        = 1'b0;
		stop_status = (group_pos_q == 2'd1) ? STATUS_BAD_LENGTH : STATUS_OK;
		if (!finished_q) begin
			if (empty_s1) begin
				stop = 1'b1;
			end else begin
				case (sym.kind)
					SYM_ILLEGAL: begin
						stop        = 1'b1;
						stop_status = STATUS_ILLEGAL;
					end
					SYM_PAD: stop = 1'b1;
					SYM_LF:  stop = (lf_next >= 2'd2);
					SYM_CR:  stop = (cr_next >= 2'd2);
					default: emit = (group_pos_q != 2'd0);
				endcase
			end
		end
	end

	always_comb begin
		case (group_pos_q)
			2'd1:    data_byte = {held_q, 2'((sym.sextet & MASK_HI2) >> 4)};
			2'd2:    data_byte = {4'(held_q & MASK_LO4), 4'((sym.sextet & MASK_MID) >> 2)};
			default: data_byte = {2'(held_q & MASK_LO2), sym.sextet};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1  <= char_byte;
			empty_s1 <= source_empty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_pos_q <= '0;
			held_q      <= '0;
			lf_count_q  <= '0;
			cr_count_q  <= '0;
			finished_q  <= 1'b0;
		end else if (take && !finished_q) begin
			if (stop) begin
				finished_q <= 1'b1;
			end else if (sym.kind == SYM_LF) begin
				lf_count_q <= lf_next;
			end else if (sym.kind == SYM_CR) begin
				cr_count_q <= cr_next;
			end else begin
				lf_count_q  <= '0;
				cr_count_q  <= '0;
				held_q      <= sym.sextet;
				group_pos_q <= group_pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && (emit || stop)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && (emit || stop)) begin
			out_byte_q   <= stop ? 8'd0 : data_byte;
			byte_valid_q <= !stop;
			last_q       <= stop;
			status_q     <= stop ? stop_status : STATUS_OK;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign last       = last_q;
	assign status     = status_q;

endmodule
`default_nettype wire

/* sv/rsd_classify.sv */
// Character classifier: maps one raw byte to a sextet or a control symbol.
`default_nettype none
module rsd_classify
	import rsd_pkg::*;
(
	input  wire logic [7:0] char_byte,
	output sym_t            sym
);

	always_comb begin
		sym.kind   = SYM_ILLEGAL;
		sym.sextet = '0;
		if (char_byte >= 8'h41 && char_byte <= 8'h5A) begin
			sym.kind   = SYM_DATA;
			sym.sextet = 6'(char_byte - 8'h41);
		end else if (char_byte >= 8'h61 && char_byte <= 8'h7A) begin
			sym.kind   = SYM_DATA;
			sym.sextet = 6'(char_byte - 8'h61 + 8'd26);
		end else if (char_byte >= 8'h30 && char_byte <= 8'h39) begin
			sym.kind   = SYM_DATA;
			sym.sextet = 6'(char_byte - 8'h30 + 8'd52);
		end else if (char_byte == CHAR_PLUS) begin
			sym.kind   = SYM_DATA;
			sym.sextet = 6'd62;
		end else if (char_byte == CHAR_SLASH) begin
			sym.kind   = SYM_DATA;
			sym.sextet = 6'd63;
		end else if (char_byte == CHAR_EQUAL) begin
			sym.kind = SYM_PAD;
		end else if (char_byte == CHAR_LF) begin
			sym.kind = SYM_LF;
		end else if (char_byte == CHAR_CR) begin
			sym.kind = SYM_CR;
		end
	end

endmodule
`default_nettype wire

/* sv/rsd_checker.sv */
// Port-level assertions for the radix-64 stream decoder, bound to the top level.
`default_nettype none
module rsd_checker
	import rsd_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       byte_valid,
	input wire logic       last,
	input wire logic [1:0] status
);

	logic ended_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ended_q <= 1'b0;
		end else if (out_valid && out_ready && last) begin
			ended_q <= 1'b1;
		end
	end

	a_none_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |-> !out_valid)
		else $error("result after terminating item");

	a_last_xor_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last != byte_valid))
		else $error("item must be either a byte or the terminator");

	a_status_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> status == STATUS_OK)
		else $error("status set on a data item");

	a_terminator_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> out_byte == 8'd0 && status != 2'd3)
		else $error("malformed terminating item");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
		else $error("result changed while stalled");

endmodule

bind radix64_stream_decoder rsd_checker u_rsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.byte_valid(byte_valid),
	.last      (last),
	.status    (status)
);
`default_nettype wire

/* bench/radix64_stream_decoder_test.sv */
// Self-checking testbench for the radix-64 stream decoder: one armored stream, ended and then flooded with dropped items.
module radix64_stream_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;
	import rsd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [7:0] data;
		logic       data_valid;
		logic       is_last;
		status_t    code;
	} decode_result_t;

	typedef enum int {
		END_PAD,
		END_DOUBLE_LF,
		END_DOUBLE_CR,
		END_ILLEGAL,
		END_SOURCE_EMPTY
	} stream_end_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] char_byte;
	logic       source_empty;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       last;
	logic [1:0] status;

	logic [1:0] grp_pos     = '0;
	logic [5:0] held_six    = '0;
	logic [1:0] lf_run      = '0;
	logic [1:0] cr_run      = '0;
	logic       stream_done = 1'b0;

	decode_result_t awaited_decodes[$];
	int mismatch_count = 0;
	int cycle_count    = 0;
	int burst_left     = 0;
	int ready_mode     = 0;
	int ready_left     = 0;

	radix64_stream_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_byte    (char_byte),
		.source_empty (source_empty),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.last         (last),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic sym_t lookup_sextet(input logic [7:0] c);
		sym_t s;
		s.kind   = SYM_DATA;
		s.sextet = '0;
		if (c >= "A" && c <= "Z") begin
			s.sextet = 6'(c - "A");
		end else if (c >= "a" && c <= "z") begin
			s.sextet = 6'(c - "a" + 8'd26);
		end else if (c >= "0" && c <= "9") begin
			s.sextet = 6'(c - "0" + 8'd52);
		end else if (c == CHAR_PLUS) begin
			s.sextet = 6'd62;
		end else if (c == CHAR_SLASH) begin
			s.sextet = 6'd63;
		end else if (c == CHAR_EQUAL) begin
			s.kind = SYM_PAD;
		end else if (c == CHAR_LF) begin
			s.kind = SYM_LF;
		end else if (c == CHAR_CR) begin
			s.kind = SYM_CR;
		end else begin
			s.kind = SYM_ILLEGAL;
		end
		return s;
	endfunction

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		if (v < 6'd26) return 8'("A" + v);
		if (v < 6'd52) return 8'("a" + (v - 6'd26));
		if (v < 6'd62) return 8'("0" + (v - 6'd52));
		if (v == 6'd62) return CHAR_PLUS;
		return CHAR_SLASH;
	endfunction

	function automatic logic [7:0] random_data_char();
		return sextet_char(6'($urandom_range(0, 63)));
	endfunction

	task automatic close_stream(input logic illegal);
		decode_result_t r;
		r.data       = '0;
		r.data_valid = 1'b0;
		r.is_last    = 1'b1;
		if (illegal) r.code = STATUS_ILLEGAL;
		else if (grp_pos == 2'd1) r.code = STATUS_BAD_LENGTH;
		else r.code = STATUS_OK;
		awaited_decodes = {awaited_decodes, r};
		stream_done = 1'b1;
	endtask

	task automatic decode_step(input logic [7:0] c, input logic empty);
		sym_t s;
		decode_result_t r;
		if (stream_done) return;
		if (empty) begin
			close_stream(1'b0);
			return;
		end
		s = lookup_sextet(c);
		case (s.kind)
			SYM_ILLEGAL: close_stream(1'b1);
			SYM_PAD: close_stream(1'b0);
			SYM_LF: begin
				lf_run = lf_run + 2'd1;
				if (lf_run >= 2'd2) close_stream(1'b0);
			end
			SYM_CR: begin
				cr_run = cr_run + 2'd1;
				if (cr_run >= 2'd2) close_stream(1'b0);
			end
			default: begin
				lf_run       = '0;
				cr_run       = '0;
				r.data_valid = 1'b1;
				r.is_last    = 1'b0;
				r.code       = STATUS_OK;
				r.data       = '0;
				case (grp_pos)
					2'd0: grp_pos = 2'd1;
					2'd1: begin
						r.data  = {held_six, s.sextet[5:4]};
						grp_pos = 2'd2;
					end
					2'd2: begin
						r.data  = {held_six[3:0], s.sextet[5:2]};
						grp_pos = 2'd3;
					end
					default: begin
						r.data  = {held_six[1:0], s.sextet};
						grp_pos = 2'd0;
					end
				endcase
				if (grp_pos != 2'd1) awaited_decodes = {awaited_decodes, r};
				held_six = s.sextet;
			end
		endcase
	endtask

	task automatic send_item(input logic [7:0] c, input logic empty);
		int  gap;
		logic took;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 32);
		end
		in_valid     <= 1'b1;
		char_byte    <= c;
		source_empty <= empty;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		burst_left--;
		decode_step(c, empty);
	endtask

	task automatic send_text(input string s);
		foreach (s[i]) send_item(s[i], 1'b0);
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_decodes.size() != 0) @(posedge clk);
	endtask

	task automatic test_alphabet_extremes();
		send_text("AAAA////AZaz09+/");
	endtask

	task automatic test_line_breaks();
		send_item(CHAR_LF, 1'b0);
		send_text("Q");
		send_item(CHAR_CR, 1'b0);
		send_item(CHAR_LF, 1'b0);
		send_text("w");
		send_item(CHAR_CR, 1'b0);
	endtask

	task automatic test_random_body();
		int sent;
		int next_drain;
		int line_len;
		sent       = 0;
		next_drain = 500;
		while (sent < 1450) begin
			line_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : $urandom_range(8, 76);
			repeat (line_len) send_item(random_data_char(), 1'b0);
			sent += line_len;
			case ($urandom_range(0, 3))
				0: send_item(CHAR_LF, 1'b0);
				1: send_item(CHAR_CR, 1'b0);
				2: begin
					send_item(CHAR_CR, 1'b0);
					send_item(CHAR_LF, 1'b0);
				end
				default: begin
					send_item(CHAR_LF, 1'b0);
					send_item(CHAR_CR, 1'b0);
				end
			endcase
			sent += 2;
			if (sent >= next_drain) begin
				wait_for_drain();
				next_drain += 500;
			end
		end
	endtask

	task automatic test_stream_end();
		int          target;
		stream_end_t cause;
		logic [7:0]  c;
		sym_t        s;
		wait_for_drain();
		target = $urandom_range(0, 1) ? 1 : $urandom_range(0, 3);
		while (grp_pos != 2'(target)) send_item(random_data_char(), 1'b0);
		cause = stream_end_t'($urandom_range(0, 4));
		case (cause)
			END_PAD: send_item(CHAR_EQUAL, 1'b0);
			END_DOUBLE_LF: while (!stream_done) send_item(CHAR_LF, 1'b0);
			END_DOUBLE_CR: while (!stream_done) send_item(CHAR_CR, 1'b0);
			END_ILLEGAL: begin
				if ($urandom_range(0, 1)) begin
					c = 8'($urandom_range(128, 255));
				end else begin
					do begin
						c = 8'($urandom_range(0, 255));
						s = lookup_sextet(c);
					end while (s.kind != SYM_ILLEGAL);
				end
				send_item(c, 1'b0);
			end
			default: send_item(8'($urandom_range(0, 255)), 1'b1);
		endcase
	endtask

	task automatic test_after_end();
		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(CHAR_EQUAL, 1'b0);
		repeat (60) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			ready_left = $urandom_range(16, 160);
		end
		ready_left--;
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 7) == 0);
			default: out_ready <= (ready_left % 5 != 0);
		endcase
	end

	always @(negedge clk) begin
		decode_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_decodes.size() == 0) begin
				$error("unexpected item: out_byte %0h byte_valid %0b last %0b status %0d",
					out_byte, byte_valid, last, status);
				mismatch_count++;
			end else begin
				want = awaited_decodes.pop_front();
				if (out_byte !== want.data) begin
					$error("out_byte mismatch: expected %0h, actual %0h", want.data, out_byte);
					mismatch_count++;
				end
				if (byte_valid !== want.data_valid) begin
					$error("byte_valid mismatch: expected %0b, actual %0b",
						want.data_valid, byte_valid);
					mismatch_count++;
				end
				if (last !== want.is_last) begin
					$error("last mismatch: expected %0b, actual %0b", want.is_last, last);
					mismatch_count++;
				end
				if (status !== want.code) begin
					$error("status mismatch: expected %0d, actual %0d", want.code, status);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		char_byte    <= '0;
		source_empty <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_alphabet_extremes();
		test_line_breaks();
		test_random_body();
		test_stream_end();
		test_after_end();
		in_valid <= 1'b0;
		while (awaited_decodes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
